// ===== rtl/core/gregorian_day_difference_assert.svh =====
// ----------------------------------------------------------------------------
// Gregorian day difference assertion macros
// Concurrent checks on clk, held off while rst is high; empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DAY_DIFFERENCE_ASSERT_SVH
`define GREGORIAN_DAY_DIFFERENCE_ASSERT_SVH

`ifndef SYNTH
`define GDD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define GDD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define GDD_ASSERT_SAME(label, ante, cons, msg)
`define GDD_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/core/gdd_pkg.sv =====
// ----------------------------------------------------------------------------
// gdd_pkg
// Shared widths, codes, calendar tables and lane interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package gdd_pkg;

  localparam int YEAR_W  = 14;
  localparam int SMALL_W = 7;
  localparam int DNUM_W  = 23;
  localparam int COUNT_W = 22;

  localparam int MAX_YEAR = 5000;

  // floor(y / 100) = (y * 5243) >> 19, exact for any 14-bit y
  localparam int DIV100_MUL   = 5243;
  localparam int DIV100_SHIFT = 19;
  localparam int DIV100_PW    = YEAR_W + 13;
  localparam int QUOT_W       = 8;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_ORDER   = 2'd2
  } status_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } gdd_stage_en_t;

  typedef struct packed {
    logic [DNUM_W-1:0]  dnum;
    logic               ok;
    logic [YEAR_W-1:0]  year;
    logic [SMALL_W-1:0] month;
  } gdd_date_t;

  function automatic logic [4:0] month_len(input logic [SMALL_W-1:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                    len = 5'd30;
      7'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days before month index mm of a year that starts in March
  function automatic logic [8:0] month_offset(input logic [3:0] mm);
    logic [8:0] off;
    unique case (mm)
      4'd0:    off = 9'd0;
      4'd1:    off = 9'd31;
      4'd2:    off = 9'd61;
      4'd3:    off = 9'd92;
      4'd4:    off = 9'd122;
      4'd5:    off = 9'd153;
      4'd6:    off = 9'd184;
      4'd7:    off = 9'd214;
      4'd8:    off = 9'd245;
      4'd9:    off = 9'd275;
      4'd10:   off = 9'd306;
      4'd11:   off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gregorian_day_difference.sv =====
// ----------------------------------------------------------------------------
// gregorian_day_difference
// Signed day count between two Gregorian dates, with date and order status.
// ----------------------------------------------------------------------------
//
//   channel  dir  tdata (low bit up)                               tuser
//   s_*      in   start_year 14, start_month 7, start_day 7,        -
//                 end_year 14, end_month 7, end_day 7 (56 bits)
//   m_*      out  day_count 22 signed, 2 zero bits                   status 2
//
// One beat in and one beat out per cycle unless m_tready holds the output; the
// path is three lane stages, then the merge register that drives m_*.
// Each stage holds its own valid bit and loads whenever it is empty or the
// stage after it moves, so s_tready stays high while bubbles remain even with
// m_tready low.
// rst clears the valid bits only; payload registers carry no reset.
//
`default_nettype none

module gregorian_day_difference
  import gdd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,   // start_year, start_month, start_day,
                                      // end_year, end_month, end_day
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // day_count, zero pad
  output logic [1:0]       m_tuser    // status
);

  // Unpack the input beat
  logic [YEAR_W-1:0]  start_year;
  logic [SMALL_W-1:0] start_month;
  logic [SMALL_W-1:0] start_day;
  logic [YEAR_W-1:0]  end_year;
  logic [SMALL_W-1:0] end_month;
  logic [SMALL_W-1:0] end_day;

  assign start_year  = s_tdata[13:0];
  assign start_month = s_tdata[20:14];
  assign start_day   = s_tdata[27:21];
  assign end_year    = s_tdata[41:28];
  assign end_month   = s_tdata[48:42];
  assign end_day     = s_tdata[55:49];

  // Pipeline occupancy and per-stage advance
  logic          stage1_valid;
  logic          stage2_valid;
  logic          stage3_valid;
  logic          rdy1;
  logic          rdy2;
  logic          rdy3;
  logic          rdy_out;
  gdd_stage_en_t en;

  assign rdy_out  = !m_tvalid || m_tready;
  assign rdy3     = !stage3_valid || rdy_out;
  assign rdy2     = !stage2_valid || rdy3;
  assign rdy1     = !stage1_valid || rdy2;
  assign s_tready = rdy1;

  assign en.s1 = rdy1;
  assign en.s2 = rdy2;
  assign en.s3 = rdy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1_valid <= 1'b0;
      stage2_valid <= 1'b0;
      stage3_valid <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (rdy1) begin
        stage1_valid <= s_tvalid;
      end
      if (rdy2) begin
        stage2_valid <= stage1_valid;
      end
      if (rdy3) begin
        stage3_valid <= stage2_valid;
      end
      if (rdy_out) begin
        m_tvalid <= stage3_valid;
      end
    end
  end

  // One lane per date, both driven by the same stage enables
  gdd_date_t date_a;
  gdd_date_t date_b;

  gdd_lane u_lane_start (
    .clk    (clk),
    .en     (en),
    .year   (start_year),
    .month  (start_month),
    .day    (start_day),
    .result (date_a)
  );

  gdd_lane u_lane_end (
    .clk    (clk),
    .en     (en),
    .year   (end_year),
    .month  (end_month),
    .day    (end_day),
    .result (date_b)
  );

  // Merge into the output register
  logic signed [COUNT_W-1:0] day_count;
  status_t                   status;

  gdd_merge u_merge (
    .clk       (clk),
    .en        (rdy_out),
    .date_a    (date_a),
    .date_b    (date_b),
    .day_count (day_count),
    .status    (status)
  );

  assign m_tdata = {2'b00, day_count};
  assign m_tuser = status;

`include "gregorian_day_difference_assert.svh"

  `GDD_ASSERT_NEXT(a_accept_fills_stage1, s_tvalid && s_tready, stage1_valid, "accepted beat lost at stage 1")
  `GDD_ASSERT_NEXT(a_stage3_reaches_out, stage3_valid && rdy_out, m_tvalid, "stage 3 beat did not reach output")
  `GDD_ASSERT_SAME(a_bad_status_zero, m_tvalid && (m_tuser != ST_OK), m_tdata == 24'd0, "nonzero count with error status")

endmodule

`default_nettype wire

// ===== rtl/core/gdd_lane.sv =====
// ----------------------------------------------------------------------------
// gdd_lane
// Three-stage date check and day-number conversion for one date.
// ----------------------------------------------------------------------------
`default_nettype none

module gdd_lane
  import gdd_pkg::*;
(
  input  wire logic                clk,
  input  wire gdd_stage_en_t       en,
  input  wire logic [YEAR_W-1:0]   year,
  input  wire logic [SMALL_W-1:0]  month,
  input  wire logic [SMALL_W-1:0]  day,
  output gdd_date_t                result
);

  // stage 1: capture, quotient by 100
  logic [YEAR_W-1:0]      y1;
  logic [SMALL_W-1:0]     m1;
  logic [SMALL_W-1:0]     d1;
  logic [QUOT_W-1:0]      q1;
  logic [DIV100_PW-1:0]   div_prod;

  assign div_prod = DIV100_PW'(year) * DIV100_PW'(DIV100_MUL);

  always_ff @(posedge clk) begin
    if (en.s1) begin
      y1 <= year;
      m1 <= month;
      d1 <= day;
      q1 <= div_prod[DIV100_SHIFT +: QUOT_W];
    end
  end

  // stage 2: leap year, validity, shifted year and month
  logic [14:0]         q_x100;
  logic [14:0]         rem;
  logic                div100;
  logic                leap;
  logic                early;
  logic                ok_c;
  logic [YEAR_W-1:0]   yy_c;
  logic [QUOT_W-1:0]   qq_c;
  logic [SMALL_W-1:0]  mm_c;

  always_comb begin
    q_x100 = 15'(q1) * 15'd100;
    rem    = 15'(y1) - q_x100;
    div100 = (rem == 15'd0);
    leap   = ((y1[1:0] == 2'd0) && !div100) || (div100 && (q1[1:0] == 2'd0));
    early  = (m1 <= 7'd2);
    yy_c   = early ? y1 - 14'd1 : y1;
    qq_c   = (early && div100) ? q1 - 8'd1 : q1;
    mm_c   = early ? m1 + 7'd9 : m1 - 7'd3;
    ok_c   = (y1 >= 14'd1) && (y1 <= YEAR_W'(MAX_YEAR)) &&
             (m1 >= 7'd1) && (m1 <= 7'd12) &&
             (d1 >= 7'd1) && (d1 <= 7'(month_len(m1, leap)));
  end

  logic [DNUM_W-1:0]   p365;
  logic [YEAR_W-1:0]   yy2;
  logic [QUOT_W-1:0]   qq2;
  logic [8:0]          off2;
  logic [4:0]          d2;
  logic                ok2;
  logic [YEAR_W-1:0]   y2;
  logic [SMALL_W-1:0]  m2;

  always_ff @(posedge clk) begin
    if (en.s2) begin
      p365 <= DNUM_W'(yy_c) * DNUM_W'(365);
      yy2  <= yy_c;
      qq2  <= qq_c;
      off2 <= month_offset(mm_c[3:0]);
      d2   <= d1[4:0];
      ok2  <= ok_c;
      y2   <= y1;
      m2   <= m1;
    end
  end

  // stage 3: add up the day number
  logic [DNUM_W-1:0] dnum_c;

  assign dnum_c = p365 + DNUM_W'(yy2[YEAR_W-1:2]) - DNUM_W'(qq2)
                + DNUM_W'(qq2[QUOT_W-1:2]) + DNUM_W'(off2) + DNUM_W'(d2);

  always_ff @(posedge clk) begin
    if (en.s3) begin
      result.dnum  <= dnum_c;
      result.ok    <= ok2;
      result.year  <= y2;
      result.month <= m2;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gdd_merge.sv =====
// ----------------------------------------------------------------------------
// gdd_merge
// Combine both lanes: validity and order status, day-number difference.
// ----------------------------------------------------------------------------
`default_nettype none

module gdd_merge
  import gdd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire gdd_date_t            date_a,
  input  wire gdd_date_t            date_b,
  output logic signed [COUNT_W-1:0] day_count,
  output status_t                   status
);

  status_t            status_c;
  logic [COUNT_W-1:0] count_c;
  logic [DNUM_W-1:0]  diff;

  assign diff = date_b.dnum - date_a.dnum;

  always_comb begin
    count_c = '0;
    priority if (!(date_a.ok && date_b.ok)) begin
      status_c = ST_INVALID;
    end else if ((date_b.year < date_a.year) ||
                 ((date_b.year == date_a.year) && (date_b.month < date_a.month))) begin
      status_c = ST_ORDER;
    end else begin
      status_c = ST_OK;
      count_c  = diff[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      day_count <= count_c;
      status    <= status_c;
    end
  end

endmodule

`default_nettype wire
